>>> rtl/scl_pkg.sv
// ----------------------------------------------------------------------------
// scl_pkg: shared types and constants of the sorted character list
// Operation codes, cell commands, control state and the vowel test.
// ----------------------------------------------------------------------------
package scl_pkg;

    typedef enum logic [2:0] {
        FN_INSERT     = 3'd0,
        FN_REMOVE_VAL = 3'd1,
        FN_REMOVE_POS = 3'd2,
        FN_READ_POS   = 3'd3,
        FN_VOWELS     = 3'd4,
        FN_CLEAR      = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE_VAL,
        OP_REMOVE_POS,
        OP_VOWEL_STEP
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     keep_head;
    } scl_ctrl_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_VOWEL
    } state_t;

    function automatic logic is_vowel(input logic [7:0] c);
        logic hit;
        hit = (c == 8'h61) || (c == 8'h65) || (c == 8'h69) || (c == 8'h6F) ||
              (c == 8'h75) || (c == 8'h41) || (c == 8'h45) || (c == 8'h49) ||
              (c == 8'h4F) || (c == 8'h55);
        return hit;
    endfunction

endpackage

>>> rtl/sorted_char_list_unit.sv
// ----------------------------------------------------------------------------
// sorted_char_list_unit: bounded list of signed characters in ascending order
// Insert, remove by value or position, read by position, vowel removal, clear.
// ----------------------------------------------------------------------------
// Every operation but vowel removal is done at once: the row of cells compares
// and shifts all entries together. Vowel removal visits each entry held in turn,
// and no new item is taken until it ends: the head entry is rotated
// to the tail of the row each cycle and dropped if it is a vowel. Results sit
// in an output register; a new item is taken when that register is empty or
// being emptied in the same cycle. Count reports the number of entries held,
// modulo 64.
module sorted_char_list_unit
    import scl_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_func,
    input  logic signed [7:0] s_value,
    input  logic [5:0]        s_position,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_ok,
    output logic signed [7:0] m_data,
    output logic [5:0]        m_count,
    output logic              m_empty_res,
    output logic              m_full_res
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 6) ? CW : 6;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     iter_reg, iter_next;
    logic              m_valid_reg;
    logic              ok_reg;
    logic signed [7:0] data_reg;
    logic [5:0]        count_out_reg;
    logic              empty_reg, full_reg;

    scl_ctrl_t         ctrl;
    logic              accept;
    logic              res_load, res_ok;
    logic signed [7:0] res_data;
    logic [XW-1:0]     pos_ext, count_ext, count_next_ext;
    logic              pos_ok, found;
    logic signed [7:0] rd_data;

    logic signed [7:0] cell_entry [CAPACITY];
    logic [CAPACITY-1:0] cell_le, cell_eq, cell_sel;

    assign pos_ext        = XW'(s_position);
    assign count_ext      = XW'(count_reg);
    assign count_next_ext = XW'(count_next);
    assign pos_ok         = (pos_ext != '0) && (pos_ext <= count_ext);
    assign found          = |cell_eq;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic              left_le;
        logic signed [7:0] left_entry;
        logic signed [7:0] right_entry;
        if (i == 0) begin : g_first
            assign left_le    = 1'b1;
            assign left_entry = cell_entry[0];
        end else begin : g_mid
            assign left_le    = cell_le[i-1];
            assign left_entry = cell_entry[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_entry = cell_entry[i];
        end else begin : g_body
            assign right_entry = cell_entry[i+1];
        end
        scl_cell #(
            .IDX (i),
            .CW  (CW),
            .XW  (XW)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .value       (s_value),
            .pos_ext     (pos_ext),
            .count       (count_reg),
            .head_entry  (cell_entry[0]),
            .left_le     (left_le),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .le          (cell_le[i]),
            .eq          (cell_eq[i]),
            .sel         (cell_sel[i])
        );
    end

    always_comb begin
        rd_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_data = rd_data | (cell_sel[i] ? cell_entry[i] : 8'sd0);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (func_t'(s_func) == FN_VOWELS) && (count_reg != '0)) begin
                    state_next = ST_VOWEL;
                end
            end
            ST_VOWEL: begin
                if (iter_reg == ONE_C) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl.op        = OP_HOLD;
        ctrl.keep_head = 1'b0;
        count_next     = count_reg;
        iter_next      = iter_reg;
        res_load       = 1'b0;
        res_ok         = 1'b0;
        res_data       = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_load = 1'b1;
                    unique case (func_t'(s_func))
                        FN_INSERT: begin
                            if (count_reg < CAP_C) begin
                                ctrl.op    = OP_INSERT;
                                count_next = count_reg + ONE_C;
                                res_ok     = 1'b1;
                            end
                        end
                        FN_REMOVE_VAL: begin
                            if (found) begin
                                ctrl.op    = OP_REMOVE_VAL;
                                count_next = count_reg - ONE_C;
                                res_ok     = 1'b1;
                            end
                        end
                        FN_REMOVE_POS: begin
                            if (pos_ok) begin
                                ctrl.op    = OP_REMOVE_POS;
                                count_next = count_reg - ONE_C;
                                res_ok     = 1'b1;
                                res_data   = rd_data;
                            end
                        end
                        FN_READ_POS: begin
                            if (pos_ok) begin
                                res_ok   = 1'b1;
                                res_data = rd_data;
                            end
                        end
                        FN_VOWELS: begin
                            if (count_reg != '0) begin
                                iter_next = count_reg;
                                res_load  = 1'b0;
                            end
                        end
                        FN_CLEAR: begin
                            count_next = '0;
                            res_ok     = 1'b1;
                        end
                        default: begin
                            res_ok = 1'b0;
                        end
                    endcase
                end
            end
            ST_VOWEL: begin
                ctrl.op        = OP_VOWEL_STEP;
                ctrl.keep_head = !is_vowel(cell_entry[0]);
                if (!ctrl.keep_head) begin
                    count_next = count_reg - ONE_C;
                end
                iter_next = iter_reg - ONE_C;
                if (iter_reg == ONE_C) begin
                    res_load = 1'b1;
                    res_ok   = 1'b1;
                end
            end
            default: begin
                ctrl.op = OP_HOLD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            iter_reg  <= iter_next;
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            ok_reg        <= res_ok;
            data_reg      <= res_data;
            count_out_reg <= count_next_ext[5:0];
            empty_reg     <= (count_next == '0);
            full_reg      <= (count_next == CAP_C);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_ok        = ok_reg;
    assign m_data      = data_reg;
    assign m_count     = count_out_reg;
    assign m_empty_res = empty_reg;
    assign m_full_res  = full_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    a_no_result_in_vowel: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_VOWEL) |-> !m_valid_reg)
        else $error("result pending during vowel removal");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (func_t'(s_func) == FN_INSERT) && (count_reg < CAP_C))
        |=> (count_reg == $past(count_reg) + ONE_C))
        else $error("insert did not advance count");

    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_empty_res && m_full_res))
        else $error("result both empty and full");

endmodule

>>> rtl/scl_cell.sv
// ----------------------------------------------------------------------------
// scl_cell: one entry of the sorted list
// Holds one character, compares it against the broadcast value and position,
// and each cycle takes its own, left, right, head or the new entry.
// ----------------------------------------------------------------------------
module scl_cell
    import scl_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 6,
    parameter int XW  = 6
) (
    input  logic              aclk,
    input  scl_ctrl_t         ctrl,
    input  logic signed [7:0] value,
    input  logic [XW-1:0]     pos_ext,
    input  logic [CW-1:0]     count,
    input  logic signed [7:0] head_entry,
    input  logic              left_le,
    input  logic signed [7:0] left_entry,
    input  logic signed [7:0] right_entry,
    output logic signed [7:0] entry,
    output logic              le,
    output logic              eq,
    output logic              sel
);

    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [CW-1:0] SLOT_C = CW'(IDX + 1);
    localparam logic [XW-1:0] POS_C  = XW'(IDX + 1);

    logic signed [7:0] entry_reg;
    logic signed [7:0] entry_next;
    logic              in_use;
    logic              lt;

    assign in_use = IDX_C < count;
    assign le     = in_use && (entry_reg <= value);
    assign lt     = in_use && (entry_reg < value);
    assign eq     = in_use && (entry_reg == value);
    assign sel    = (POS_C == pos_ext);
    assign entry  = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            OP_HOLD: begin
                entry_next = entry_reg;
            end
            OP_INSERT: begin
                if (le) begin
                    entry_next = entry_reg;
                end else if (left_le) begin
                    entry_next = value;
                end else begin
                    entry_next = left_entry;
                end
            end
            OP_REMOVE_VAL: begin
                if (!lt) begin
                    entry_next = right_entry;
                end
            end
            OP_REMOVE_POS: begin
                if (POS_C >= pos_ext) begin
                    entry_next = right_entry;
                end
            end
            OP_VOWEL_STEP: begin
                if (ctrl.keep_head && (SLOT_C == count)) begin
                    entry_next = head_entry;
                end else begin
                    entry_next = right_entry;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: regression bench for the sorted character list unit
// A table of directed items followed by random phases (fill, mixed, drain and
// vowel-heavy) drives the list through empty, full and refused cases. Each
// result is compared field by field with the table's expected result or with a
// local model of the ordered list; both handshakes idle at random, and the
// result side holds off once long enough to back the input up.
// ----------------------------------------------------------------------------
module tb;
    import scl_pkg::*;

    localparam int CAPACITY       = 32;
    localparam int NUM_DIR        = 25;
    localparam int NUM_RANDOM     = 1250;
    localparam int TOTAL_ITEMS    = NUM_DIR + NUM_RANDOM;
    localparam int QUIET_TAIL     = 100;
    localparam int HOLD_CYCLES    = 200;
    localparam int HOLD_AFTER     = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 2 * CAPACITY + 8;

    localparam logic [2:0]  FN_SPARE_LO = 3'd6;
    localparam logic [2:0]  FN_SPARE_HI = 3'd7;
    localparam logic [79:0] VOWEL_SET   = "aeiouAEIOU";

    typedef enum int {MODE_FILL, MODE_MIX, MODE_DRAIN, MODE_VOWEL} mix_mode_t;

    typedef struct packed {
        logic [2:0]        func;
        logic signed [7:0] value;
        logic [5:0]        pos;
    } op_item_t;

    typedef struct packed {
        logic              ok;
        logic signed [7:0] data;
        logic [5:0]        count;
        logic              empty_res;
        logic              full_res;
    } list_result_t;

    typedef struct packed {
        op_item_t     op;
        logic         typed;
        list_result_t want;
    } dir_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [2:0]        s_func;
    logic signed [7:0] s_value;
    logic [5:0]        s_position;
    logic              m_valid;
    logic              m_ready;
    logic              m_ok;
    logic signed [7:0] m_data;
    logic [5:0]        m_count;
    logic              m_empty_res;
    logic              m_full_res;

    sorted_char_list_unit #(.CAPACITY(CAPACITY)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_value     (s_value),
        .s_position  (s_position),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_ok        (m_ok),
        .m_data      (m_data),
        .m_count     (m_count),
        .m_empty_res (m_empty_res),
        .m_full_res  (m_full_res)
    );

    logic signed [7:0] held [CAPACITY];
    int                n_held;
    list_result_t      pending_q [$];
    dir_row_t          dir_tbl [NUM_DIR];

    int items_sent    = 0;
    int results_seen  = 0;
    int fail_count    = 0;
    int refused_seen  = 0;
    int full_seen     = 0;
    int vowel_passes  = 0;
    int idle_cycles   = 0;
    wire quiet = items_sent >= TOTAL_ITEMS - QUIET_TAIL;

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic logic is_vowel_char(input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < 10; k++) begin
            if (c == VOWEL_SET[8*k +: 8]) hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic void drop_entry(input int idx);
        for (int i = idx; i + 1 < n_held; i++) held[i] = held[i + 1];
        n_held--;
    endfunction

    function automatic list_result_t apply_list_op(input op_item_t it);
        list_result_t      r;
        logic signed [7:0] v;
        int                at;
        int                j;
        r = '0;
        v = it.value;
        case (it.func)
            FN_INSERT: begin
                if (n_held < CAPACITY) begin
                    at = 0;
                    while (at < n_held && held[at] <= v) at++;
                    for (int i = n_held; i > at; i--) held[i] = held[i - 1];
                    held[at] = v;
                    n_held++;
                    r.ok = 1'b1;
                end
            end
            FN_REMOVE_VAL: begin
                for (int i = 0; i < n_held; i++) begin
                    if (held[i] == v) begin
                        drop_entry(i);
                        r.ok = 1'b1;
                        break;
                    end
                    if (held[i] > v) break;
                end
            end
            FN_REMOVE_POS, FN_READ_POS: begin
                if (it.pos >= 1 && it.pos <= n_held) begin
                    r.data = held[it.pos - 1];
                    if (it.func == FN_REMOVE_POS) drop_entry(it.pos - 1);
                    r.ok = 1'b1;
                end
            end
            FN_VOWELS: begin
                if (n_held > 0) begin
                    j = 0;
                    for (int i = 0; i < n_held; i++) begin
                        if (!is_vowel_char(held[i])) begin
                            held[j] = held[i];
                            j++;
                        end
                    end
                    n_held = j;
                    r.ok = 1'b1;
                    vowel_passes++;
                end
            end
            FN_CLEAR: begin
                n_held = 0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.count     = 6'(n_held);
        r.empty_res = (n_held == 0);
        r.full_res  = (n_held == CAPACITY);
        return r;
    endfunction

    function automatic op_item_t gen_op(input mix_mode_t mode);
        op_item_t it;
        int       w [6];
        int       roll;
        int       acc;
        int       pick;
        case (mode)
            MODE_FILL:  w = '{78, 6, 5, 6, 3, 1};
            MODE_MIX:   w = '{35, 19, 16, 18, 6, 3};
            MODE_DRAIN: w = '{15, 30, 30, 15, 6, 2};
            default:    w = '{55, 8, 10, 12, 12, 1};
        endcase
        roll = $urandom_range(0, 99);
        acc  = 0;
        pick = 6;
        for (int k = 5; k >= 0; k--) begin
            acc = 0;
            for (int m = 0; m <= k; m++) acc += w[m];
            if (roll < acc) pick = k;
        end
        case (pick)
            0: it.func = FN_INSERT;
            1: it.func = FN_REMOVE_VAL;
            2: it.func = FN_READ_POS;
            3: it.func = FN_REMOVE_POS;
            4: it.func = FN_VOWELS;
            5: it.func = FN_CLEAR;
            default: it.func = $urandom_range(0, 1) ? FN_SPARE_HI : FN_SPARE_LO;
        endcase
        it.value = 8'($urandom);
        if (mode == MODE_VOWEL && $urandom_range(0, 1))
            it.value = VOWEL_SET[8*$urandom_range(0, 9) +: 8];
        if (it.func == FN_REMOVE_VAL && n_held > 0 && $urandom_range(0, 9) < 7)
            it.value = held[$urandom_range(0, n_held - 1)];
        if (n_held > 0 && $urandom_range(0, 3) != 0)
            it.pos = 6'($urandom_range(1, n_held));
        else
            it.pos = 6'($urandom_range(0, 63));
        return it;
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 30;
        endcase
    endfunction

    task automatic send_op(input op_item_t it, input logic use_typed,
                           input list_result_t typed_res);
        list_result_t r;
        s_valid    <= 1'b1;
        s_func     <= it.func;
        s_value    <= it.value;
        s_position <= it.pos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = apply_list_op(it);
        pending_q.push_back(use_typed ? typed_res : r);
        items_sent++;
    endtask

    task automatic sender_gap(input int gap_pct);
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    initial begin : stim
        mix_mode_t mode;
        int        phase_len;
        int        gap_pct;
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_func     <= '0;
        s_value    <= '0;
        s_position <= '0;
        n_held = 0;
        dir_tbl = '{
            '{'{FN_VOWELS,     8'sh00, 6'd0},  1'b1, '{1'b0, 8'sh00, 6'd0, 1'b1, 1'b0}},
            '{'{FN_READ_POS,   8'sh00, 6'd1},  1'b1, '{1'b0, 8'sh00, 6'd0, 1'b1, 1'b0}},
            '{'{FN_REMOVE_POS, 8'sh00, 6'd0},  1'b1, '{1'b0, 8'sh00, 6'd0, 1'b1, 1'b0}},
            '{'{FN_REMOVE_VAL, 8'sh80, 6'd0},  1'b1, '{1'b0, 8'sh00, 6'd0, 1'b1, 1'b0}},
            '{'{FN_SPARE_LO,   8'sh00, 6'd0},  1'b1, '{1'b0, 8'sh00, 6'd0, 1'b1, 1'b0}},
            '{'{FN_SPARE_HI,   8'sh7F, 6'd63}, 1'b1, '{1'b0, 8'sh00, 6'd0, 1'b1, 1'b0}},
            '{'{FN_CLEAR,      8'sh00, 6'd0},  1'b1, '{1'b1, 8'sh00, 6'd0, 1'b1, 1'b0}},
            '{'{FN_INSERT,     8'sh80, 6'd0},  1'b1, '{1'b1, 8'sh00, 6'd1, 1'b0, 1'b0}},
            '{'{FN_INSERT,     8'sh7F, 6'd0},  1'b1, '{1'b1, 8'sh00, 6'd2, 1'b0, 1'b0}},
            '{'{FN_INSERT,     8'sh61, 6'd0},  1'b0, '0},
            '{'{FN_INSERT,     8'sh45, 6'd0},  1'b0, '0},
            '{'{FN_INSERT,     8'sh61, 6'd0},  1'b0, '0},
            '{'{FN_INSERT,     8'sh00, 6'd0},  1'b0, '0},
            '{'{FN_INSERT,     8'shFF, 6'd0},  1'b0, '0},
            '{'{FN_READ_POS,   8'sh00, 6'd0},  1'b1, '{1'b0, 8'sh00, 6'd7, 1'b0, 1'b0}},
            '{'{FN_READ_POS,   8'sh00, 6'd63}, 1'b1, '{1'b0, 8'sh00, 6'd7, 1'b0, 1'b0}},
            '{'{FN_READ_POS,   8'sh00, 6'd1},  1'b1, '{1'b1, 8'sh80, 6'd7, 1'b0, 1'b0}},
            '{'{FN_READ_POS,   8'sh00, 6'd7},  1'b0, '0},
            '{'{FN_REMOVE_POS, 8'sh00, 6'd8},  1'b1, '{1'b0, 8'sh00, 6'd7, 1'b0, 1'b0}},
            '{'{FN_REMOVE_POS, 8'sh00, 6'd7},  1'b0, '0},
            '{'{FN_REMOVE_VAL, 8'sh7F, 6'd0},  1'b0, '0},
            '{'{FN_REMOVE_VAL, 8'sh61, 6'd0},  1'b0, '0},
            '{'{FN_VOWELS,     8'sh00, 6'd0},  1'b0, '0},
            '{'{FN_VOWELS,     8'sh00, 6'd0},  1'b0, '0},
            '{'{FN_CLEAR,      8'sh00, 6'd0},  1'b1, '{1'b1, 8'sh00, 6'd0, 1'b1, 1'b0}}
        };
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        gap_pct = 30;
        for (int r = 0; r < NUM_DIR; r++) begin
            send_op(dir_tbl[r].op, dir_tbl[r].typed, dir_tbl[r].want);
            sender_gap(gap_pct);
        end

        mode      = MODE_FILL;
        phase_len = 60;
        while (items_sent < TOTAL_ITEMS) begin
            for (int k = 0; k < phase_len && items_sent < TOTAL_ITEMS; k++) begin
                send_op(gen_op(mode), 1'b0, '0);
                sender_gap(gap_pct);
            end
            mode      = mix_mode_t'($urandom_range(0, 3));
            phase_len = $urandom_range(20, 80);
            gap_pct   = pick_idle_pct();
        end
        s_valid <= 1'b0;

        while (pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("ran %0d items, %0d results: %0d refused, %0d while full, %0d vowel passes",
                 items_sent, results_seen, refused_seen, full_seen, vowel_passes);
        if (fail_count == 0 && pending_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : sink
        int  stall_pct;
        logic held_off;
        stall_pct = 10;
        held_off  = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 63) == 0) stall_pct = pick_idle_pct();
            if (!held_off && results_seen >= HOLD_AFTER) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (!m_ok) refused_seen++;
            if (m_full_res) full_seen++;
            if (pending_q.size() == 0) begin
                $error("result with no item pending");
                fail_count++;
            end else begin
                want = pending_q.pop_front();
                check_field("ok", want.ok, m_ok);
                check_field("data", $signed(want.data), $signed(m_data));
                check_field("count", want.count, m_count);
                check_field("empty_res", want.empty_res, m_empty_res);
                check_field("full_res", want.full_res, m_full_res);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

>>> filelist.f
rtl/scl_pkg.sv
rtl/scl_cell.sv
rtl/sorted_char_list_unit.sv
tb/tb.sv
